// ===== src/swdp_pkg.sv =====
// ============================================================================
// swdp_pkg
// Shared types and fixed-point constants for the seawater density pipeline.
// ============================================================================
package swdp_pkg;

    localparam int Q_W    = 64;     // signed fixed-point word, 48 fraction bits
    localparam int FRAC   = 48;
    localparam int IN_W   = 48;     // slave tdata width
    localparam int OUT_W  = 32;     // master tdata width
    localparam int TEMP_W = 20;
    localparam int SAL_W  = 22;
    localparam int DENS_W = 27;
    localparam int TMAG_W = 19;

    typedef logic signed [Q_W-1:0] t_q;

    localparam logic signed [TEMP_W-1:0] T_MIN = -20'sd50000;
    localparam logic signed [TEMP_W-1:0] T_MAX = 20'sd400000;
    localparam logic [SAL_W-1:0]         S_MAX = 22'd2752512;
    localparam logic [DENS_W-1:0]        D_MIN = 27'd64225280;
    localparam logic [DENS_W-1:0]        D_MAX = 27'd68157440;

    // t = round(T * 2^44 / 625): 2^44 = 625 * T_HI + T_LO, remainder part by reciprocal
    localparam logic [34:0] T_HI    = 35'd28147497671;
    localparam logic [5:0]  T_LO    = 6'd41;
    localparam logic [8:0]  T_RND   = 9'd312;
    localparam logic [24:0] T_RECIP = 25'd27487791;   // ceil(2^34 / 625)
    localparam int          T_SHIFT = 34;

    localparam int SQ_STEPS = 31;   // one root bit per stage

    // coefficients, round(c * 2^48), half up
    localparam t_q K0  = 64'(((128'd999842594 << 48) + 128'd500000) / 128'd1000000);
    localparam t_q K1  = 64'(((128'd6793952 << 48) + 128'd50000000) / 128'd100000000);
    localparam t_q K2  = 64'(((128'd909529 << 48) + 128'd50000000) / 128'd100000000);
    localparam t_q K3  = 64'(((128'd1001685 << 48) + 128'd5000000000) / 128'd10000000000);
    localparam t_q K4  = 64'(((128'd1120083 << 48) + 128'd500000000000)
                             / 128'd1000000000000);
    localparam t_q K5  = 64'(((128'd6536332 << 48) + 128'd500000000000000)
                             / 128'd1000000000000000);
    localparam t_q K6  = 64'(((128'd824493 << 48) + 128'd500000) / 128'd1000000);
    localparam t_q K7  = 64'(((128'd40899 << 48) + 128'd5000000) / 128'd10000000);
    localparam t_q K8  = 64'(((128'd76438 << 48) + 128'd500000000) / 128'd1000000000);
    localparam t_q K9  = 64'(((128'd82467 << 48) + 128'd50000000000) / 128'd100000000000);
    localparam t_q K10 = 64'(((128'd53875 << 48) + 128'd5000000000000)
                             / 128'd10000000000000);
    localparam t_q K11 = 64'(((128'd572466 << 48) + 128'd50000000) / 128'd100000000);
    localparam t_q K12 = 64'(((128'd10227 << 48) + 128'd50000000) / 128'd100000000);
    localparam t_q K13 = 64'(((128'd16546 << 48) + 128'd5000000000) / 128'd10000000000);
    localparam t_q K14 = 64'(((128'd48314 << 48) + 128'd50000000) / 128'd100000000);

endpackage

// ===== src/seawater_density_polynomial.sv =====
// Throughput: one request per cycle while the output skid stage is empty; the 4-stage
// multipliers and the 31-stage bit-per-stage square root set the depth.
// Back-pressure stalls the whole pipeline once the output skid stage is full.
// Reset (synchronous, active low) clears valid bits only; no clearing pass.
// ============================================================================
// seawater_density_polynomial
// Seawater density at one atmosphere from temperature and practical salinity.
// ============================================================================
module seawater_density_polynomial (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [swdp_pkg::IN_W-1:0] i_s_axis_tdata,   // [19:0] temperature, [41:20] salinity
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [swdp_pkg::OUT_W-1:0] o_m_axis_tdata   // [26:0] density
);
    import swdp_pkg::*;

    localparam int NSTG = 45;

    logic               w_en, w_acc, w_take;
    logic [NSTG-1:0]    r_vld;

    // stage 1: saturate
    logic signed [TEMP_W-1:0] w_tv, w_tsat;
    logic [SAL_W-1:0]         w_sv;
    logic                     r_tneg1, r_tneg2, r_tneg3;
    logic [TMAG_W-1:0]        r_tmag;
    logic [SAL_W-1:0]         r_s1;

    // temperature scaling
    logic [53:0]        r_tprod2, r_tprod3;
    logic [23:0]        r_ty;
    logic [14:0]        r_tcorr;
    logic [48:0]        w_tcm;
    logic [54:0]        w_tq;
    t_q                 r_t;
    t_q                 r_td [1:16];

    // salinity line and root
    logic [SAL_W-1:0]   r_sd [1:32];
    logic [63:0]        r_sqx [1:SQ_STEPS];
    logic [63:0]        r_sqr [1:SQ_STEPS];
    logic [63:0]        w_nx [1:SQ_STEPS];
    logic [63:0]        w_nr [1:SQ_STEPS];
    t_q                 r_sq;
    t_q                 w_s1, w_s20, w_s33;

    // polynomial terms
    t_q w_p8, w_p12, w_p16, w_p20, w_p24;
    t_q w_a8, w_a12, w_a16, w_a20;
    t_q w_b8, w_b12;
    t_q w_s2_5, w_d9_9, w_as24, w_s15_37, w_bs41;
    t_q r_bd [1:25];
    t_q r_pd [1:17];
    t_q r_asd [1:17];
    t_q r_dd [1:32];
    t_q r_sum1, r_sum2, r_rho;
    logic [63:0]        w_rnd;
    logic [31:0]        r_rnd;
    logic [DENS_W-1:0]  r_res, r_out, r_skid;
    logic               r_out_vld, r_skid_vld;

    assign w_en            = !r_skid_vld;
    assign o_s_axis_tready = w_en;
    assign w_acc           = i_s_axis_tvalid && w_en;
    assign w_take          = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], w_acc};
        end
    end

    // ---------------- stage 1 ----------------
    always_comb begin
        w_tv   = $signed(i_s_axis_tdata[TEMP_W-1:0]);
        w_sv   = i_s_axis_tdata[TEMP_W+SAL_W-1:TEMP_W];
        w_tsat = (w_tv < T_MIN) ? T_MIN : ((w_tv > T_MAX) ? T_MAX : w_tv);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tneg1 <= w_tsat[TEMP_W-1];
            r_tmag  <= w_tsat[TEMP_W-1] ? TMAG_W'(-w_tsat) : TMAG_W'(w_tsat);
            r_s1    <= (w_sv > S_MAX) ? S_MAX : w_sv;
        end
    end

    // ---------------- temperature to Q.48 ----------------
    assign w_tcm = r_ty * T_RECIP;
    assign w_tq  = {1'b0, r_tprod3} + {40'd0, r_tcorr};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tprod2 <= r_tmag * T_HI;
            r_ty     <= 24'(r_tmag * T_LO) + 24'(T_RND);
            r_tneg2  <= r_tneg1;
            r_tprod3 <= r_tprod2;
            r_tcorr  <= w_tcm[T_SHIFT+14:T_SHIFT];
            r_tneg3  <= r_tneg2;
            r_t      <= r_tneg3 ? -$signed({9'd0, w_tq}) : $signed({9'd0, w_tq});
            r_td[1]  <= r_t;
            for (int k = 2; k <= 16; k++) r_td[k] <= r_td[k-1];
        end
    end

    // ---------------- salinity delay and square root ----------------
    always_comb begin
        logic [63:0] v_x, v_r, v_rb, v_bit;
        for (int j = 1; j <= SQ_STEPS; j++) begin
            v_bit = 64'd1 << (62 - 2 * j);
            if (j == 1) begin
                v_x = {2'd0, r_s1, 40'd0};
                v_r = '0;
            end else begin
                v_x = r_sqx[j-1];
                v_r = r_sqr[j-1];
            end
            v_rb = v_r + v_bit;
            if (v_x >= v_rb) begin
                w_nx[j] = v_x - v_rb;
                w_nr[j] = (v_r >> 1) + v_bit;
            end else begin
                w_nx[j] = v_x;
                w_nr[j] = v_r >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 1; j <= SQ_STEPS; j++) begin
                r_sqx[j] <= w_nx[j];
                r_sqr[j] <= w_nr[j];
            end
            // round to nearest: bump when remainder exceeds root
            r_sq <= $signed({12'd0, r_sqr[SQ_STEPS][31:0]
                             + 32'(r_sqx[SQ_STEPS] > r_sqr[SQ_STEPS]), 20'd0});
            r_sd[1] <= r_s1;
            for (int k = 2; k <= 32; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    assign w_s1  = $signed({10'd0, r_s1, 32'd0});
    assign w_s20 = $signed({10'd0, r_sd[19], 32'd0});
    assign w_s33 = $signed({10'd0, r_sd[32], 32'd0});

    // ---------------- pure water polynomial ----------------
    swdp_mul u_mp1 (.i_clk, .i_en(w_en), .i_a(K5),   .i_b(r_t),     .i_c(-K4),
                    .i_sub(1'b0), .o_p(w_p8));
    swdp_mul u_mp2 (.i_clk, .i_en(w_en), .i_a(w_p8),  .i_b(r_td[4]),  .i_c(K3),
                    .i_sub(1'b0), .o_p(w_p12));
    swdp_mul u_mp3 (.i_clk, .i_en(w_en), .i_a(w_p12), .i_b(r_td[8]),  .i_c(-K2),
                    .i_sub(1'b0), .o_p(w_p16));
    swdp_mul u_mp4 (.i_clk, .i_en(w_en), .i_a(w_p16), .i_b(r_td[12]), .i_c(K1),
                    .i_sub(1'b0), .o_p(w_p20));
    swdp_mul u_mp5 (.i_clk, .i_en(w_en), .i_a(w_p20), .i_b(r_td[16]), .i_c(K0),
                    .i_sub(1'b0), .o_p(w_p24));

    // ---------------- salinity coefficient A(t) ----------------
    swdp_mul u_ma1 (.i_clk, .i_en(w_en), .i_a(K10),   .i_b(r_t),     .i_c(-K9),
                    .i_sub(1'b0), .o_p(w_a8));
    swdp_mul u_ma2 (.i_clk, .i_en(w_en), .i_a(w_a8),  .i_b(r_td[4]),  .i_c(K8),
                    .i_sub(1'b0), .o_p(w_a12));
    swdp_mul u_ma3 (.i_clk, .i_en(w_en), .i_a(w_a12), .i_b(r_td[8]),  .i_c(-K7),
                    .i_sub(1'b0), .o_p(w_a16));
    swdp_mul u_ma4 (.i_clk, .i_en(w_en), .i_a(w_a16), .i_b(r_td[12]), .i_c(K6),
                    .i_sub(1'b0), .o_p(w_a20));

    // ---------------- B(t) = (d7 - d8 t) t - d6 ----------------
    swdp_mul u_mb1 (.i_clk, .i_en(w_en), .i_a(K13),   .i_b(r_t),     .i_c(K12),
                    .i_sub(1'b1), .o_p(w_b8));
    swdp_mul u_mb2 (.i_clk, .i_en(w_en), .i_a(w_b8),  .i_b(r_td[4]),  .i_c(-K11),
                    .i_sub(1'b0), .o_p(w_b12));

    // ---------------- salinity products ----------------
    swdp_mul u_ms2  (.i_clk, .i_en(w_en), .i_a(w_s1),   .i_b(w_s1),    .i_c('0),
                     .i_sub(1'b0), .o_p(w_s2_5));
    swdp_mul u_md9  (.i_clk, .i_en(w_en), .i_a(K14),    .i_b(w_s2_5),  .i_c('0),
                     .i_sub(1'b0), .o_p(w_d9_9));
    swdp_mul u_mas  (.i_clk, .i_en(w_en), .i_a(w_a20),  .i_b(w_s20),   .i_c('0),
                     .i_sub(1'b0), .o_p(w_as24));
    swdp_mul u_ms15 (.i_clk, .i_en(w_en), .i_a(w_s33),  .i_b(r_sq),    .i_c('0),
                     .i_sub(1'b0), .o_p(w_s15_37));
    swdp_mul u_mbs  (.i_clk, .i_en(w_en), .i_a(r_bd[25]), .i_b(w_s15_37), .i_c('0),
                     .i_sub(1'b0), .o_p(w_bs41));

    // ---------------- alignment, sum, round ----------------
    assign w_rnd = r_rho[Q_W-1] ? 64'd0 : 64'(r_rho) + (64'd1 << 31);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bd[1]  <= w_b12;
            for (int k = 2; k <= 25; k++) r_bd[k] <= r_bd[k-1];
            r_pd[1]  <= w_p24;
            r_asd[1] <= w_as24;
            for (int k = 2; k <= 17; k++) begin
                r_pd[k]  <= r_pd[k-1];
                r_asd[k] <= r_asd[k-1];
            end
            r_dd[1]  <= w_d9_9;
            for (int k = 2; k <= 32; k++) r_dd[k] <= r_dd[k-1];

            r_sum1 <= r_pd[17] + r_asd[17];
            r_sum2 <= w_bs41 + r_dd[32];
            r_rho  <= r_sum1 + r_sum2;
            r_rnd  <= w_rnd[63:32];
            r_res  <= (r_rnd < 32'(D_MIN)) ? D_MIN :
                      ((r_rnd > 32'(D_MAX)) ? D_MAX : r_rnd[DENS_W-1:0]);
        end
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld  <= w_en ? r_vld[NSTG-1] : 1'b1;
            r_skid_vld <= 1'b0;
        end else if (w_en && r_vld[NSTG-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_en ? r_res : r_skid;
        end else if (w_en && r_vld[NSTG-1]) begin
            r_skid <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_W-DENS_W){1'b0}}, r_out};

endmodule

// ===== src/swdp_mul.sv =====
// ============================================================================
// swdp_mul
// Pipelined Q.48 multiply-add: o_p = i_c +/- round(i_a * i_b / 2^48).
// Sign-magnitude product, ties away from zero, four register stages.
// ============================================================================
module swdp_mul (
    input  logic          i_clk,
    input  logic          i_en,
    input  swdp_pkg::t_q  i_a,
    input  swdp_pkg::t_q  i_b,
    input  swdp_pkg::t_q  i_c,
    input  logic          i_sub,
    output swdp_pkg::t_q  o_p
);
    import swdp_pkg::*;

    logic [Q_W-1:0]     r_ma, r_mb;
    logic               r_neg1, r_neg2, r_neg3;
    t_q                 r_c1, r_c2, r_c3, r_p;
    logic [63:0]        r_p00, r_p01, r_p10, r_p11;
    logic [Q_W-2:0]     r_q;
    logic [127:0]       w_full;

    assign w_full = {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                  + {r_p11, 64'd0} + (128'd1 << (FRAC - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= i_a[Q_W-1] ? Q_W'(-i_a) : Q_W'(i_a);
            r_mb   <= i_b[Q_W-1] ? Q_W'(-i_b) : Q_W'(i_b);
            r_neg1 <= i_a[Q_W-1] ^ i_b[Q_W-1] ^ i_sub;
            r_c1   <= i_c;

            r_p00  <= r_ma[31:0]  * r_mb[31:0];
            r_p01  <= r_ma[31:0]  * r_mb[63:32];
            r_p10  <= r_ma[63:32] * r_mb[31:0];
            r_p11  <= r_ma[63:32] * r_mb[63:32];
            r_neg2 <= r_neg1;
            r_c2   <= r_c1;

            r_q    <= w_full[FRAC+Q_W-2:FRAC];
            r_neg3 <= r_neg2;
            r_c3   <= r_c2;

            r_p    <= r_neg3 ? r_c3 - $signed({1'b0, r_q}) : r_c3 + $signed({1'b0, r_q});
        end
    end

    assign o_p = r_p;

endmodule
